// File: hdl/srr_pkg.sv
// Shared definitions for the selective-repeat receiver: field widths,
// result kind codes, default window sizes and the sequencer state type.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package srr_pkg;

    localparam int SEQ_W            = 16;
    localparam int PAY_W            = 64;
    localparam int DEF_WINDOW_SIZE  = 4;
    localparam int DEF_BUFFER_DEPTH = 8;

    // Result kind codes.
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// File: hdl/srr_ifs.sv
// Valid/ready channel interfaces for incoming packets and outgoing results.
// Depends on srr_pkg for the field widths.
`default_nettype none

interface srr_pkt_if
    import srr_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             checksum_ok;
    logic [SEQ_W-1:0] seq_num;
    logic [PAY_W-1:0] payload_word;

    modport source (output valid, checksum_ok, seq_num, payload_word, input ready);
    modport sink   (input valid, checksum_ok, seq_num, payload_word, output ready);
endinterface

interface srr_res_if
    import srr_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [SEQ_W-1:0] ack_num;
    logic [PAY_W-1:0] delivered_payload;
    logic             last;

    modport source (output valid, kind, ack_num, delivered_payload, last, input ready);
    modport sink   (input valid, kind, ack_num, delivered_payload, last, output ready);
endinterface

`default_nettype wire

// File: hdl/srr_slot_ram.sv
// Payload buffer: one write port, one read port, registered read data.
// Depends on srr_pkg for the payload width and the default depth.
`default_nettype none

module srr_slot_ram
    import srr_pkg::*;
#(
    parameter  int DEPTH = DEF_BUFFER_DEPTH,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [PAY_W-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [PAY_W-1:0] o_rdata
);

    logic [PAY_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds when no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/selective_repeat_receiver.sv
// Top level of the selective-repeat receiver window.
// Depends on srr_pkg, the channel interfaces in srr_ifs and srr_slot_ram.
//
// Usage. Packets arrive on i_pkt (checksum flag, 16-bit sequence number and
// one 64-bit payload word); results leave on o_res, each either an
// acknowledgement (kind 0, ack_num set) or an in-order delivery (kind 1,
// delivered_payload set), with last marking the final result of a packet.
// A request is taken when valid and ready are both high at a clock edge.
//
// Timing. A packet that fails the checksum or falls outside both the
// current and the previous window is absorbed with no result. Any other
// packet shows its acknowledgement in the output register on the cycle
// after it is taken. A packet at the window base then passes a read state
// that reads the payload buffer and an emit state that delivers one
// payload per cycle while the result side does not stall, d deliveries in
// all (1 <= d <= WINDOW_SIZE); the payload buffer has registered read data,
// and its next read is issued as each delivery is emitted.
// Only one packet is in progress at a time.
//
// Reset clears the window base and every slot's filled flag at once; no
// clearing pass is needed. If the result side stalls, the output register
// holds its request and the sequencer waits; a new packet is taken only
// when the output register is free or being emptied in the same cycle.
`default_nettype none

module selective_repeat_receiver
    import srr_pkg::*;
#(
    parameter int WINDOW_SIZE  = DEF_WINDOW_SIZE,
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    srr_pkt_if.sink   i_pkt,
    srr_res_if.source o_res
);

    // Slot index width, delivery counter width and the slot lookup table.
    localparam int IW      = $clog2(BUFFER_DEPTH);
    localparam int CW      = $clog2(WINDOW_SIZE + 1);
    localparam int TW      = $clog2(2 * BUFFER_DEPTH + WINDOW_SIZE + 1);
    localparam int TAB_N   = 2 ** TW;
    // Going past 2^16 moves the slot by this much less than the step.
    localparam int WRAP_C  = (1 << SEQ_W) % BUFFER_DEPTH;
    localparam int WRAP_AD = BUFFER_DEPTH - WRAP_C;
    localparam logic [SEQ_W-1:0] PREV_LO = SEQ_W'((1 << SEQ_W) - WINDOW_SIZE);

    t_state r_state, n_state;

    logic [SEQ_W-1:0]        r_base, n_base;
    logic [IW-1:0]           r_base_slot, n_base_slot;
    logic [BUFFER_DEPTH-1:0] r_filled, n_filled;
    logic [CW-1:0]           r_cnt, n_cnt;

    logic             r_out_valid, n_out_valid;
    logic             r_kind, n_kind;
    logic [SEQ_W-1:0] r_ack, n_ack;
    logic [PAY_W-1:0] r_pay, n_pay;
    logic             r_last, n_last;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic             ram_re;
    logic [IW-1:0]    ram_raddr;
    logic [PAY_W-1:0] ram_rdata;

    // Constant table giving g mod BUFFER_DEPTH for small g.
    logic [IW-1:0] mod_tab [TAB_N];
    for (genvar g = 0; g < TAB_N; g++) begin : g_mod_tab
        assign mod_tab[g] = IW'(g % BUFFER_DEPTH);
    end

    logic                    out_free;
    logic                    accept;
    logic [SEQ_W-1:0]        seq_off;
    logic                    is_base, in_win, in_prev, seq_wrap;
    logic [TW-1:0]           seq_idx;
    logic [IW-1:0]           seq_slot;
    logic [SEQ_W:0]          clr_sum;
    logic [TW-1:0]           clr_idx;
    logic [IW-1:0]           clr_slot;
    logic [IW-1:0]           next_slot;
    logic [BUFFER_DEPTH-1:0] filled_clr;
    logic [CW-1:0]           cnt_inc;
    logic                    deliv_last;

    assign out_free    = !r_out_valid || o_res.ready;
    // Packets are taken only between sequences, once the output register
    // can hold the acknowledgement.
    assign i_pkt.ready = (r_state == ST_IDLE) && out_free;
    assign accept      = i_pkt.valid && i_pkt.ready;

    // Window classification relative to the base, modulo 2^16.
    assign seq_off  = i_pkt.seq_num - r_base;
    assign is_base  = (seq_off == '0);
    assign in_win   = (seq_off < SEQ_W'(WINDOW_SIZE));
    assign in_prev  = (seq_off >= PREV_LO);
    assign seq_wrap = (i_pkt.seq_num < r_base);

    // Slot of the incoming sequence number, derived from the base slot and
    // the distance; only meaningful for packets inside the window.
    assign seq_idx  = TW'(r_base_slot) + TW'(seq_off)
                    + (seq_wrap ? TW'(WRAP_AD) : TW'(0));
    assign seq_slot = mod_tab[seq_idx];

    // Slot that enters the top of the window when the base moves on.
    assign clr_sum  = {1'b0, r_base} + (SEQ_W + 1)'(WINDOW_SIZE);
    assign clr_idx  = TW'(r_base_slot) + TW'(WINDOW_SIZE)
                    + (clr_sum[SEQ_W] ? TW'(WRAP_AD) : TW'(0));
    assign clr_slot = mod_tab[clr_idx];

    // Slot of base + 1; the slot restarts at zero when the base wraps.
    assign next_slot = (r_base == '1 || r_base_slot == IW'(BUFFER_DEPTH - 1))
                     ? '0 : r_base_slot + IW'(1);

    assign filled_clr = r_filled
                      & ~(BUFFER_DEPTH'(1) << r_base_slot)
                      & ~(BUFFER_DEPTH'(1) << clr_slot);
    assign cnt_inc    = r_cnt + CW'(1);
    assign deliv_last = (cnt_inc == CW'(WINDOW_SIZE)) || !filled_clr[next_slot];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_pkt.checksum_ok && is_base) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free && deliv_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath control and register updates.
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = seq_slot;
        ram_re      = 1'b0;
        ram_raddr   = r_base_slot;
        n_base      = r_base;
        n_base_slot = r_base_slot;
        n_filled    = r_filled;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_res.ready;
        n_kind      = r_kind;
        n_ack       = r_ack;
        n_pay       = r_pay;
        n_last      = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_pkt.checksum_ok) begin
                    // Inside the window: buffer the payload.
                    if (in_win) begin
                        ram_we             = 1'b1;
                        n_filled[seq_slot] = 1'b1;
                    end
                    // Current or previous window: acknowledge.
                    if (in_win || in_prev) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_ACK;
                        n_ack       = i_pkt.seq_num;
                        n_pay       = '0;
                        n_last      = !is_base;
                    end
                    n_cnt = '0;
                end
            end
            ST_READ: begin
                // The base slot was filled by the packet just taken.
                ram_re    = 1'b1;
                ram_raddr = r_base_slot;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_DELIVER;
                    n_ack       = '0;
                    n_pay       = ram_rdata;
                    n_last      = deliv_last;
                    n_filled    = filled_clr;
                    n_base      = r_base + SEQ_W'(1);
                    n_base_slot = next_slot;
                    n_cnt       = cnt_inc;
                    // Fetch the following slot while this delivery leaves.
                    if (!deliv_last) begin
                        ram_re    = 1'b1;
                        ram_raddr = next_slot;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_base      <= '0;
            r_base_slot <= '0;
            r_filled    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_base_slot <= n_base_slot;
            r_filled    <= n_filled;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_ack  <= n_ack;
        r_pay  <= n_pay;
        r_last <= n_last;
    end

    srr_slot_ram #(
        .DEPTH (BUFFER_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_pkt.payload_word),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_res.valid             = r_out_valid;
    assign o_res.kind              = r_kind;
    assign o_res.ack_num           = r_ack;
    assign o_res.delivered_payload = r_pay;
    assign o_res.last              = r_last;

endmodule

`default_nettype wire

// File: tb/sv/tb_selective_repeat_receiver.sv
`timescale 1ns / 1ps
// Self-checking testbench for the selective-repeat receiver window: directed
// and random packets, with a scoreboard class that predicts each result.
// Depends on srr_pkg, the channel interfaces in srr_ifs and the block itself.

module tb_selective_repeat_receiver
    import srr_pkg::*;
;

    localparam int WIN_SIZE     = DEF_WINDOW_SIZE;
    localparam int WIN_DEPTH    = DEF_BUFFER_DEPTH;
    localparam int RANDOM_ITEMS = 72;   // random packets that draw at least one result
    localparam int QUIET_AFTER  = 56;   // from here on neither side idles
    localparam int IDLE_LIMIT   = 200;  // cycles with no request taken on either side
    localparam int DRAIN_CYCLES = 2 + WIN_SIZE + 6;

    typedef struct packed {
        logic             kind;
        logic [SEQ_W-1:0] ack_num;
        logic [PAY_W-1:0] delivered_payload;
        logic             last;
    } t_result;

    // Tracks the receive window as the block should, and holds the results
    // still owed by the block in the order it must produce them.
    class arq_window_board;
        logic [SEQ_W-1:0] base;
        logic             filled [WIN_DEPTH];
        logic [PAY_W-1:0] stored [WIN_DEPTH];
        t_result          awaited_results [$];
        int               mismatch_count;

        function new();
            base = '0;
            mismatch_count = 0;
            foreach (filled[i]) begin
                filled[i] = 1'b0;
                stored[i] = '0;
            end
        endfunction

        function int slot_index(logic [SEQ_W-1:0] seq);
            return int'(seq % WIN_DEPTH);
        endfunction

        function void owe(logic kind, logic [SEQ_W-1:0] ack, logic [PAY_W-1:0] pay);
            t_result r;
            r.kind = kind;
            r.ack_num = ack;
            r.delivered_payload = pay;
            r.last = 1'b0;
            awaited_results.push_back(r);
        endfunction

        // Works out the results of one accepted packet and returns how many.
        function int take_packet(logic ok, logic [SEQ_W-1:0] seq, logic [PAY_W-1:0] pay);
            logic [SEQ_W-1:0] seq_off;
            int               before_cnt;
            int               sent;
            before_cnt = awaited_results.size();
            if (!ok) return 0;
            seq_off = seq - base;
            if (seq_off == '0) begin
                owe(KIND_ACK, seq, '0);
                stored[slot_index(seq)] = pay;
                filled[slot_index(seq)] = 1'b1;
                // Release the in-order run, at most one window's worth.
                sent = 0;
                while (sent < WIN_SIZE && filled[slot_index(base)]) begin
                    owe(KIND_DELIVER, '0, stored[slot_index(base)]);
                    filled[slot_index(base)] = 1'b0;
                    filled[slot_index(SEQ_W'(base + WIN_SIZE))] = 1'b0;
                    base = base + 1'b1;
                    sent++;
                end
            end else if (seq_off < WIN_SIZE) begin
                stored[slot_index(seq)] = pay;
                filled[slot_index(seq)] = 1'b1;
                owe(KIND_ACK, seq, '0);
            end else if (seq_off >= (1 << SEQ_W) - WIN_SIZE) begin
                owe(KIND_ACK, seq, '0);
            end
            if (awaited_results.size() > before_cnt)
                awaited_results[awaited_results.size()-1].last = 1'b1;
            return awaited_results.size() - before_cnt;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: kind %0d ack %h payload %h last %0d",
                             got.kind, got.ack_num, got.delivered_payload, got.last);
                return;
            end
            want = awaited_results.pop_front();
            if (got.kind !== want.kind || got.ack_num !== want.ack_num ||
                got.delivered_payload !== want.delivered_payload ||
                got.last !== want.last) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Result mismatch at %0t", $realtime);
                    $display("  expected: kind %0d ack %h payload %h last %0d",
                             want.kind, want.ack_num, want.delivered_payload, want.last);
                    $display("  actual:   kind %0d ack %h payload %h last %0d",
                             got.kind, got.ack_num, got.delivered_payload, got.last);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    srr_pkt_if pkt ();
    srr_res_if res ();

    selective_repeat_receiver #(
        .WINDOW_SIZE  (WIN_SIZE),
        .BUFFER_DEPTH (WIN_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt),
        .o_res   (res)
    );

    arq_window_board sb;
    bit              quiet;        // set for the last part of the run: no idling at all
    int              answered;     // accepted packets that drew at least one result
    int              idle_cycles;
    int              stall_left;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Offers one packet and waits for it to be taken. Valid is only lowered
    // at the start of an idle burst, so a back-to-back request never sees
    // valid dropped and raised within the same time step.
    task automatic send_packet(input logic ok, input logic [SEQ_W-1:0] seq,
                               input logic [PAY_W-1:0] pay);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            pkt.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pkt.valid        <= 1'b1;
        pkt.checksum_ok  <= ok;
        pkt.seq_num      <= seq;
        pkt.payload_word <= pay;
        @(posedge i_clk);
        while (!pkt.ready) @(posedge i_clk);
        if (sb.take_packet(ok, seq, pay) > 0)
            answered++;
    endtask

    function automatic logic [PAY_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Result side: takes results with random stall bursts and checks each
    // one against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (res.valid && res.ready)
                sb.check_result({res.kind, res.ack_num, res.delivered_payload, res.last});
            if (stall_left > 0) begin
                res.ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                res.ready  <= 1'b0;
                stall_left <= $urandom_range(0, 4);
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a correct run never goes long without a request on either side.
    always @(posedge i_clk) begin
        if (i_rst_n && !(pkt.valid && pkt.ready) && !(res.valid && res.ready)) begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    initial begin
        logic             ok;
        logic [SEQ_W-1:0] seq;
        int               pick;
        int               random_start;

        sb               = new();
        quiet            = 1'b0;
        answered         = 0;
        idle_cycles      = 0;
        i_rst_n          = 1'b0;
        pkt.valid        = 1'b0;
        pkt.checksum_ok  = 1'b0;
        pkt.seq_num      = '0;
        pkt.payload_word = '0;
        res.ready        = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Right after reset the previous window wraps below zero.
        send_packet(1'b1, 16'hFFFF, '0);
        send_packet(1'b1, 16'hFFFC, '1);
        send_packet(1'b1, 16'hFFFB, rand_word());   // just below the previous window
        send_packet(1'b0, 16'h0000, '1);            // failed checksum at the base
        send_packet(1'b1, 16'h0004, rand_word());   // one past the window
        send_packet(1'b1, 16'h8000, rand_word());
        // Fill the window out of order, with a duplicate, then complete it:
        // the base packet releases a full window of deliveries.
        send_packet(1'b1, 16'h0002, rand_word());
        send_packet(1'b1, 16'h0003, rand_word());
        send_packet(1'b1, 16'h0002, rand_word());
        send_packet(1'b1, 16'h0001, '1);
        send_packet(1'b1, 16'h0000, rand_word());
        // Base is now 4: old packets are acknowledged again, older ones dropped.
        send_packet(1'b1, 16'h0003, rand_word());
        send_packet(1'b1, 16'h0000, rand_word());
        send_packet(1'b1, 16'hFFFF, rand_word());
        send_packet(1'b0, 16'h0004, rand_word());
        send_packet(1'b1, 16'h0004, '1);            // single delivery
        send_packet(1'b1, 16'h0007, rand_word());
        send_packet(1'b1, 16'h0006, rand_word());
        send_packet(1'b1, 16'h0008, rand_word());   // top of the window
        send_packet(1'b1, 16'h0005, rand_word());   // delivery run stops at the cap
        send_packet(1'b1, 16'h0009, '0);

        // Random part: mostly packets in or just behind the window, so the
        // window keeps moving, with some noise and failed checksums mixed in.
        random_start = answered;
        while (answered - random_start < RANDOM_ITEMS) begin
            if (answered - random_start >= QUIET_AFTER)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            ok   = 1'b1;
            if (pick < 70) begin
                seq = sb.base + SEQ_W'($urandom_range(0, WIN_SIZE - 1));
            end else if (pick < 80) begin
                seq = sb.base - SEQ_W'($urandom_range(1, WIN_SIZE));
            end else if (pick < 90) begin
                seq = SEQ_W'($urandom);
            end else begin
                ok  = 1'b0;
                seq = (pick < 95) ? sb.base : SEQ_W'($urandom);
            end
            send_packet(ok, seq, rand_word());
        end
        pkt.valid <= 1'b0;

        while (sb.awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0 && sb.awaited_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
